// ----- rtl/tlr_pkg.sv -----
// Shared constants, codes and types of the telnet line receiver.
package tlr_pkg;

  localparam int unsigned MaxLine = 512;
  localparam int unsigned StoreCap = (MaxLine < 512) ? MaxLine : 512;

  localparam int unsigned CapW = 10;
  localparam int unsigned CountW = 9;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ActW = 3;

  localparam logic [CapW-1:0] CapReset = CapW'(StoreCap);

  localparam logic [ByteW-1:0] ByteIac = 8'd255;
  localparam logic [ByteW-1:0] ByteDont = 8'd254;
  localparam logic [ByteW-1:0] ByteDo = 8'd253;
  localparam logic [ByteW-1:0] ByteWont = 8'd252;
  localparam logic [ByteW-1:0] ByteWill = 8'd251;
  localparam logic [ByteW-1:0] ByteSb = 8'd250;
  localparam logic [ByteW-1:0] ByteSe = 8'd240;
  localparam logic [ByteW-1:0] ByteDel = 8'd127;
  localparam logic [ByteW-1:0] ByteBs = 8'd8;
  localparam logic [ByteW-1:0] ByteCr = 8'd13;
  localparam logic [ByteW-1:0] ByteLf = 8'd10;
  localparam logic [ByteW-1:0] ByteSpace = 8'd32;

  typedef enum logic [ActW-1:0] {
    ActNone  = 3'd0,
    ActStore = 3'd1,
    ActErase = 3'd2,
    ActLine  = 3'd3,
    ActDisc  = 3'd4
  } action_e;

  typedef enum logic [4:0] {
    ModeText   = 5'b00001,
    ModeCmd    = 5'b00010,
    ModeOpt    = 5'b00100,
    ModeSub    = 5'b01000,
    ModeSubIac = 5'b10000
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [CountW-1:0] count;
    logic              cr_pending;
  } state_t;

  typedef struct packed {
    action_e           action;
    logic [ByteW-1:0]  char_byte;
    logic [CountW-1:0] char_index;
    logic [CountW-1:0] line_length;
  } result_t;

endpackage

// ----- rtl/tlr_in_if.sv -----
// Valid/ready channel that carries received bytes into the line receiver.
interface tlr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       same_read;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output same_read,
                  output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input same_read,
                input end_of_stream, output ready);
endinterface

// ----- rtl/tlr_out_if.sv -----
// Valid/ready channel that carries edit results out of the line receiver.
interface tlr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] char_byte;
  logic [8:0] char_index;
  logic [8:0] line_length;

  modport source (output valid, output action, output char_byte,
                  output char_index, output line_length, input ready);
  modport sink (input valid, input action, input char_byte,
                input char_index, input line_length, output ready);
endinterface

// ----- rtl/telnet_line_receiver_unit.sv -----
// Top level of the telnet line receiver: state, capacity register and result stage.
//
// The receiver takes one byte beat per clock while its result stage is free and
// gives one result beat for each, in the cycle after the byte is taken. The
// parser state and the line count are updated in the same cycle that the byte
// is taken, and the result register frees itself in the cycle that its beat is
// taken, so a sink that is always ready sees a sustained rate of one byte per
// clock; a stalled sink holds the input side after one result is waiting.
module telnet_line_receiver_unit
  import tlr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  tlr_in_if.sink          rx_i,
  tlr_out_if.source       res_o
);

  state_t          state_q;
  state_t          state_d;
  result_t         res_d;
  logic [CapW-1:0] limit_q;
  logic [CapW-1:0] limit_d;
  logic            free;
  logic            accept;

  assign rx_i.ready = free;
  assign accept = rx_i.valid && free;

  assign limit_d = (cfg_wdata_i > CapReset) ? CapReset : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= CapReset;
    end else if (cfg_we_i) begin
      limit_q <= limit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode <= ModeText;
      state_q.count <= '0;
      state_q.cr_pending <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  tlr_step u_step (
    .st_i    (state_q),
    .limit_i (limit_q),
    .data_i  (rx_i.data_byte),
    .same_i  (rx_i.same_read),
    .eos_i   (rx_i.end_of_stream),
    .st_o    (state_d),
    .res_o   (res_d)
  );

  tlr_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .res_i  (res_d),
    .free_o (free),
    .res_o  (res_o)
  );

endmodule

// ----- rtl/tlr_step.sv -----
// Per-byte telnet parser and line editor: next state and result of one beat.
module tlr_step
  import tlr_pkg::*;
(
  input  state_t          st_i,
  input  logic [CapW-1:0] limit_i,
  input  logic [ByteW-1:0] data_i,
  input  logic            same_i,
  input  logic            eos_i,
  output state_t          st_o,
  output result_t         res_o
);

  logic [CapW-1:0]   count_ext;
  logic [CountW-1:0] count_dec;
  logic              fits;

  assign count_ext = {1'b0, st_i.count};
  assign count_dec = st_i.count - CountW'(1);
  assign fits = (count_ext + CapW'(1)) < limit_i;

  always_comb begin
    st_o = st_i;
    st_o.cr_pending = 1'b0;
    res_o.action = ActNone;
    res_o.char_byte = '0;
    res_o.char_index = '0;
    res_o.line_length = st_i.count;

    if (eos_i) begin
      st_o.mode = ModeText;
      st_o.count = '0;
      res_o.action = ActDisc;
      res_o.line_length = '0;
    end else begin
      unique case (st_i.mode)
        ModeCmd: begin
          if (data_i == ByteWill || data_i == ByteWont ||
              data_i == ByteDo || data_i == ByteDont) begin
            st_o.mode = ModeOpt;
          end else if (data_i == ByteSb) begin
            st_o.mode = ModeSub;
          end else begin
            st_o.mode = ModeText;
          end
        end
        ModeOpt: begin
          st_o.mode = ModeText;
        end
        ModeSub: begin
          if (data_i == ByteIac) begin
            st_o.mode = ModeSubIac;
          end
        end
        ModeSubIac: begin
          if (data_i == ByteSe) begin
            st_o.mode = ModeText;
          end else if (data_i != ByteIac) begin
            st_o.mode = ModeSub;
          end
        end
        default: begin
          st_o.mode = ModeText;
          priority if (st_i.cr_pending && same_i && data_i == ByteLf) begin
            // A CR LF pair from one read ends the line only once.
          end else if (data_i == ByteIac) begin
            st_o.mode = ModeCmd;
          end else if (data_i == ByteCr || data_i == ByteLf) begin
            st_o.cr_pending = (data_i == ByteCr);
            st_o.count = '0;
            res_o.action = ActLine;
          end else if (data_i == ByteBs || data_i == ByteDel) begin
            if (st_i.count != '0) begin
              st_o.count = count_dec;
              res_o.action = ActErase;
              res_o.char_index = count_dec;
              res_o.line_length = count_dec;
            end
          end else if (data_i < ByteSpace) begin
            // Other control bytes are dropped.
          end else if (fits) begin
            st_o.count = st_i.count + CountW'(1);
            res_o.action = ActStore;
            res_o.char_byte = data_i;
            res_o.char_index = st_i.count;
            res_o.line_length = st_i.count + CountW'(1);
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/tlr_out_stage.sv -----
// Result register that holds one finished beat until the sink takes it.
module tlr_out_stage
  import tlr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  result_t  res_i,
  output logic     free_o,
  tlr_out_if.source res_o
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign free_o = !valid_q || res_o.ready;
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid = valid_q;
  assign res_o.action = res_q.action;
  assign res_o.char_byte = res_q.char_byte;
  assign res_o.char_index = res_q.char_index;
  assign res_o.line_length = res_q.line_length;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the telnet line receiver, with a built-in line editor predictor.
`timescale 1ns / 1ps

module tb;
  import tlr_pkg::*;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             same;
    logic             eos;
    bit               drain_first;
  } rx_beat_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [CapW-1:0] cfg_wdata_i = '0;

  tlr_in_if  rx_if ();
  tlr_out_if res_if ();

  telnet_line_receiver_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  rx_beat_t    pending_bytes[$];
  result_t     expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  logic [ByteW-1:0] verbs[4] = '{ByteWill, ByteWont, ByteDo, ByteDont};

  mode_e           edit_mode = ModeText;
  int unsigned     edit_len = 0;
  bit              edit_cr = 1'b0;
  logic [CapW-1:0] edit_capacity = CapReset;

  rx_beat_t next_beat;
  rx_beat_t taken_beat;
  result_t  seen_result;
  result_t  want_result;

  function automatic result_t edit_line_byte(rx_beat_t b);
    result_t     r;
    bit          had_cr;
    int unsigned limit;
    r = '0;
    r.action = ActNone;
    had_cr = edit_cr;
    edit_cr = 1'b0;
    if (b.eos) begin
      edit_mode = ModeText;
      edit_len = 0;
      r.action = ActDisc;
      return r;
    end
    r.line_length = CountW'(edit_len);
    case (edit_mode)
      ModeCmd: begin
        if (b.data == ByteWill || b.data == ByteWont || b.data == ByteDo ||
            b.data == ByteDont) begin
          edit_mode = ModeOpt;
        end else if (b.data == ByteSb) begin
          edit_mode = ModeSub;
        end else begin
          edit_mode = ModeText;
        end
        return r;
      end
      ModeOpt: begin
        edit_mode = ModeText;
        return r;
      end
      ModeSub: begin
        if (b.data == ByteIac) edit_mode = ModeSubIac;
        return r;
      end
      ModeSubIac: begin
        if (b.data == ByteSe) edit_mode = ModeText;
        else if (b.data != ByteIac) edit_mode = ModeSub;
        return r;
      end
      default: edit_mode = ModeText;
    endcase
    if (had_cr && b.same && b.data == ByteLf) return r;
    if (b.data == ByteIac) begin
      edit_mode = ModeCmd;
      return r;
    end
    if (b.data == ByteCr || b.data == ByteLf) begin
      r.action = ActLine;
      edit_cr = (b.data == ByteCr);
      edit_len = 0;
      return r;
    end
    if (b.data == ByteBs || b.data == ByteDel) begin
      if (edit_len > 0) begin
        edit_len--;
        r.action = ActErase;
        r.char_index = CountW'(edit_len);
        r.line_length = CountW'(edit_len);
      end
      return r;
    end
    if (b.data < ByteSpace) return r;
    limit = (edit_capacity > StoreCap) ? StoreCap : edit_capacity;
    if (edit_len + 1 < limit) begin
      r.action = ActStore;
      r.char_byte = b.data;
      r.char_index = CountW'(edit_len);
      edit_len++;
      r.line_length = CountW'(edit_len);
    end
    return r;
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rx_if.valid = 1'b0;
    rx_if.data_byte = '0;
    rx_if.same_read = 1'b0;
    rx_if.end_of_stream = 1'b0;
    res_if.ready = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          (!pending_bytes[0].drain_first ||
           (!rx_if.valid && expected_results.size() == 0 && !res_if.valid))) begin
        next_beat = pending_bytes.pop_front();
        rx_if.valid <= 1'b1;
        rx_if.data_byte <= next_beat.data;
        rx_if.same_read <= next_beat.same;
        rx_if.end_of_stream <= next_beat.eos;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        taken_beat.data = rx_if.data_byte;
        taken_beat.same = rx_if.same_read;
        taken_beat.eos = rx_if.end_of_stream;
        taken_beat.drain_first = 1'b0;
        expected_results.push_back(edit_line_byte(taken_beat));
      end
      if (res_if.valid && res_if.ready) begin
        seen_result = {res_if.action, res_if.char_byte, res_if.char_index,
                       res_if.line_length};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected: action %0d char %0d",
                   $time, seen_result.action, seen_result.char_byte,
                   " index %0d length %0d",
                   seen_result.char_index, seen_result.line_length);
        end else begin
          want_result = expected_results.pop_front();
          if (seen_result !== want_result) begin
            mismatch_count++;
            $display("%0t: expected action %0d char %0d index %0d length %0d",
                     $time, want_result.action, want_result.char_byte,
                     want_result.char_index, want_result.line_length,
                     ", got action %0d char %0d index %0d length %0d",
                     seen_result.action, seen_result.char_byte,
                     seen_result.char_index, seen_result.line_length);
          end
        end
      end
    end
  end

  function automatic logic rand_same();
    return ($urandom_range(9) != 0);
  endfunction

  task automatic push_beat(input logic [ByteW-1:0] data, input logic same,
                           input logic eos = 1'b0, input bit hold = 1'b0);
    rx_beat_t b;
    b.data = data;
    b.same = same;
    b.eos = eos;
    b.drain_first = hold;
    pending_bytes.push_back(b);
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || rx_if.valid || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    edit_capacity = value;
  endtask

  task automatic add_traffic(input int unsigned budget, input bit long_lines);
    int unsigned start;
    int unsigned n;
    int unsigned pick;
    start = pending_bytes.size();
    if (long_lines) begin
      repeat ($urandom_range(600, 560)) begin
        push_beat(ByteW'($urandom_range(254, 32)), rand_same());
      end
    end
    while (pending_bytes.size() - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        n = $urandom_range(12, 1);
        repeat (n) push_beat(ByteW'($urandom_range(254, 32)), rand_same());
      end else if (pick < 40) begin
        repeat ($urandom_range(4, 1)) begin
          push_beat($urandom_range(1) ? ByteBs : ByteDel, rand_same());
        end
      end else if (pick < 55) begin
        case ($urandom_range(3))
          0: push_beat(ByteCr, rand_same());
          1: push_beat(ByteLf, rand_same());
          2: begin
            push_beat(ByteCr, rand_same());
            push_beat(ByteLf, 1'b1);
          end
          default: begin
            push_beat(ByteCr, rand_same());
            push_beat(ByteLf, 1'b0);
          end
        endcase
      end else if (pick < 65) begin
        push_beat(ByteIac, rand_same());
        push_beat(verbs[2'($urandom_range(3))], rand_same());
        push_beat(ByteW'($urandom_range(255)), rand_same());
      end else if (pick < 72) begin
        push_beat(ByteIac, rand_same());
        push_beat(ByteW'($urandom_range(255)), rand_same());
      end else if (pick < 80) begin
        push_beat(ByteIac, rand_same());
        push_beat(ByteSb, rand_same());
        repeat ($urandom_range(6)) begin
          if ($urandom_range(3) == 0) push_beat(ByteIac, rand_same());
          push_beat(ByteW'($urandom_range(255)), rand_same());
        end
        if ($urandom_range(5) != 0) begin
          push_beat(ByteIac, rand_same());
          push_beat(ByteSe, rand_same());
        end
      end else if (pick < 88) begin
        push_beat(ByteW'($urandom_range(31)), rand_same());
      end else if (pick < 97) begin
        push_beat(ByteW'($urandom_range(255)), rand_same());
      end else begin
        push_beat(ByteW'($urandom_range(255)), rand_same(), 1'b1);
      end
    end
    pending_bytes[start + (pending_bytes.size() - start) / 2].drain_first = 1'b1;
  endtask

  task automatic run_phase(input logic [CapW-1:0] cap, input int unsigned send_pct,
                           input int unsigned stall, input int unsigned budget,
                           input bit long_lines);
    wait_idle();
    set_capacity(cap);
    send_idle_pct = send_pct;
    stall_pct = stall;
    add_traffic(budget, long_lines);
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With a capacity of four, the fourth character finds the line full.
    set_capacity(CapW'(4));
    push_beat(8'd97, 1'b0);
    push_beat(8'd98, 1'b1);
    push_beat(8'd99, 1'b1);
    push_beat(8'd100, 1'b1);
    push_beat(ByteBs, 1'b1);
    push_beat(ByteDel, 1'b1);
    push_beat(ByteBs, 1'b1);
    push_beat(ByteBs, 1'b1);
    push_beat(ByteSpace, 1'b0);
    push_beat(8'd254, 1'b1);
    push_beat(ByteCr, 1'b0);
    push_beat(ByteLf, 1'b1);
    push_beat(ByteLf, 1'b1);
    push_beat(8'd0, 1'b0);
    push_beat(ByteIac, 1'b1);
    push_beat(ByteWill, 1'b1);
    push_beat(ByteIac, 1'b1);
    push_beat(ByteIac, 1'b1);
    push_beat(8'd241, 1'b1);
    push_beat(ByteIac, 1'b1);
    push_beat(ByteSb, 1'b1);
    push_beat(ByteIac, 1'b1);
    push_beat(ByteIac, 1'b1);
    push_beat(8'd1, 1'b1);
    push_beat(ByteIac, 1'b1);
    push_beat(ByteSe, 1'b1);
    push_beat(8'd120, 1'b1);
    push_beat(8'd255, 1'b1, 1'b1);
    push_beat(8'd121, 1'b0, 1'b0, 1'b1);

    run_phase(CapW'(5), 71, 0, 100, 1'b0);
    run_phase(CapW'(2), 0, 71, 100, 1'b0);
    run_phase(CapW'(1), 30, 30, 80, 1'b0);
    run_phase(CapW'(0), 0, 0, 80, 1'b0);
    run_phase(CapW'(1023), 0, 0, 650, 1'b1);
    run_phase(CapW'(3), 71, 0, 80, 1'b0);
    run_phase(CapW'($urandom_range(512, 2)), 0, 71, 100, 1'b0);
    run_phase(CapW'(40), 30, 30, 100, 1'b0);
    run_phase(CapW'(512), 0, 71, 120, 1'b0);

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
